// ----- sv/bgf_pkg.sv -----
// Battery gauge filter: shared widths, constants, payload structs and register indexes.
// No dependencies; imported by bgf_mul, bgf_div and the top level.
package bgf_pkg;

  // Ring depth and derived widths
  localparam int MAX_WINDOW = 20;
  localparam int RING_AW    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int FILL_W     = $clog2(MAX_WINDOW + 1);

  // Field widths
  localparam int MV_W       = 16;
  localparam int PCT_W      = 7;
  localparam int LEN_CFG_W  = 5;
  localparam int RING_W     = MV_W + PCT_W;

  // Arithmetic widths
  localparam int SUM_MV_W   = MV_W + FILL_W;
  localparam int SUM_PCT_W  = PCT_W + FILL_W;
  localparam int PROD_W     = MV_W + PCT_W;
  localparam int DIV_W      = (SUM_MV_W > PROD_W) ? SUM_MV_W : PROD_W;
  localparam int DVS_W      = (FILL_W > PCT_W) ? FILL_W : PCT_W;

  // Config port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_LENGTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RAMP_INTERVAL  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EMPTY_MV       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FULL_MV        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_LIMIT_MV   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FULL_LIMIT_PCT = 3'd5;

  // Reset values
  localparam logic [FILL_W-1:0] RST_FILTER_LENGTH  = FILL_W'(5);
  localparam logic [MV_W-1:0]   RST_RAMP_INTERVAL  = 16'd30;
  localparam logic [MV_W-1:0]   RST_EMPTY_MV       = 16'd2800;
  localparam logic [MV_W-1:0]   RST_FULL_MV        = 16'd4062;
  localparam logic [MV_W-1:0]   RST_LOW_LIMIT_MV   = 16'd0;
  localparam logic [PCT_W-1:0]  RST_FULL_LIMIT_PCT = 7'd100;

  // Behavior constants
  localparam logic [PCT_W-1:0]  RAMP_CAP     = 7'd99;
  localparam logic [DVS_W-1:0]  PCT_SCALE    = DVS_W'(100);
  localparam logic [1:0]        SETTLE_COUNT = 2'd2;

  typedef enum logic [1:0] {
    PS_DISC = 2'd0,
    PS_CONN = 2'd1,
    PS_CHRG = 2'd2
  } pstate_e;

  typedef struct packed {
    logic             charge_level;
    logic             pg_pin_level;
    logic [MV_W-1:0]  raw_mv;
    logic [PCT_W-1:0] raw_pct;
    logic             adc_ok;
  } bgf_in_t;

  typedef struct packed {
    logic [1:0]       power_state;
    logic             is_charging;
    logic             is_connected;
    logic [MV_W-1:0]  shown_mv;
    logic [PCT_W-1:0] shown_pct;
    logic             critically_low;
    logic             fully_charged;
    logic             meas_error;
  } bgf_out_t;

endpackage

// ----- sv/bgf_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bgf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic                                    re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/bgf_mul.sv -----
// Bit-serial shift-add multiplier: percent times millivolt span, one multiplier bit a cycle.
// Depends on bgf_pkg.
module bgf_mul
  import bgf_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [PCT_W-1:0]  a_i,
  input  logic [MV_W-1:0]   b_i,
  output logic              done_o,
  output logic [PROD_W-1:0] prod_o
);

  localparam int CNT_W = $clog2(PCT_W + 1);

  logic [MV_W-1:0]  hi_q, hi_d;
  logic [PCT_W-1:0] lo_q, lo_d;
  logic [MV_W-1:0]  b_q, b_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [MV_W:0]    sum;

  always_comb begin
    sum    = {1'b0, hi_q} + {1'b0, (lo_q[0] ? b_q : '0)};
    hi_d   = hi_q;
    lo_d   = lo_q;
    b_d    = b_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      hi_d   = '0;
      lo_d   = a_i;
      b_d    = b_i;
      cnt_d  = CNT_W'(PCT_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      hi_d  = sum[MV_W:1];
      lo_d  = {sum[0], lo_q[PCT_W-1:1]};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hi_q   <= '0;
      lo_q   <= '0;
      b_q    <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      hi_q   <= hi_d;
      lo_q   <= lo_d;
      b_q    <= b_d;
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  assign done_o = done_q;
  assign prod_o = {hi_q, lo_q};

endmodule

// ----- sv/bgf_div.sv -----
// Restoring bit-serial divider: one quotient bit a cycle, narrow remainder.
// Depends on bgf_pkg.
module bgf_div
  import bgf_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DIV_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DIV_W-1:0] quo_o
);

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic [DVS_W-1:0] rem_q, rem_d;
  logic [DIV_W-1:0] quo_q, quo_d;
  logic [DVS_W-1:0] dvs_q, dvs_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             ge;

  always_comb begin
    // shift next dividend bit into the partial remainder
    trial  = {rem_q, quo_q[DIV_W-1]};
    ge     = (trial >= {1'b0, dvs_q});
    diff   = trial - {1'b0, dvs_q};
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
      cnt_d  = CNT_W'(DIV_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      quo_d = {quo_q[DIV_W-2:0], ge};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      quo_q  <= '0;
      dvs_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      rem_q  <= rem_d;
      quo_q  <= quo_d;
      dvs_q  <= dvs_d;
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// ----- sv/battery_gauge_filter_top.sv -----
// Battery gauge filter top level: power state tracking, charge ramp, moving average.
// Depends on bgf_pkg, bgf_ram, bgf_mul, bgf_div.
//
//   channel | valid       | stall        | payload            | direction
//   --------+-------------+--------------+--------------------+----------
//   sample  | in_valid_i  | in_stall_o   | in_i  (bgf_in_t)   | in
//   result  | out_valid_o | out_stall_i  | out_o (bgf_out_t)  | out
//   config  | cfg_we_i    | (none)       | cfg_idx_i/data_i   | in
//
// One request in flight at a time; in_stall_o is high from acceptance until the
// result is loaded into the output register. Averaging request: fill reads of the
// ring RAM plus the 23-step serial divider. Ramp step: the 7-step serial multiply,
// then the divide by 100 in the same divider. Other requests skip the arithmetic
// and go straight to the output register.
// Reset clears all control state and loads register defaults; the ring RAM is
// not cleared, fill count guards it. A stalled result holds the next request in
// its final state until the output register frees up.
module battery_gauge_filter_top
  import bgf_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // sample channel
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  bgf_in_t               in_i,
  // result channel
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output bgf_out_t              out_o,
  // config write port
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_SUM,
    S_MUL,
    S_DIV,
    S_EMIT
  } state_e;

  // control / state registers
  state_e              state_q, state_d;
  pstate_e             run_q, run_d;
  logic [1:0]          settle_q, settle_d;
  logic [MV_W-1:0]     rc_q, rc_d;
  logic [RING_AW-1:0]  pos_q, pos_d;
  logic [FILL_W-1:0]   fill_q, fill_d;
  logic [MV_W-1:0]     held_mv_q, held_mv_d;
  logic [PCT_W-1:0]    held_pct_q, held_pct_d;
  logic [FILL_W-1:0]   cnt_q, cnt_d;
  logic                rd_vld_q, rd_vld_d;
  logic                ramp_q, ramp_d;
  logic                mul_start_q, mul_start_d;
  logic                div_start_q, div_start_d;
  logic                out_valid_q, out_valid_d;

  // latched request
  logic                chg_q, chg_d;
  logic                con_q, con_d;
  logic [MV_W-1:0]     mv_q, mv_d;
  logic [PCT_W-1:0]    pct_q, pct_d;
  logic                ok_q, ok_d;

  // accumulators and result
  logic [SUM_MV_W-1:0]  smv_q, smv_d;
  logic [SUM_PCT_W-1:0] spct_q, spct_d;
  bgf_out_t             out_q, out_d;

  // config registers
  logic [FILL_W-1:0]   len_q, len_d;
  logic [MV_W-1:0]     ri_q, ri_d;
  logic [MV_W-1:0]     empty_q, empty_d;
  logic [MV_W-1:0]     full_q, full_d;
  logic [MV_W-1:0]     low_q, low_d;
  logic [PCT_W-1:0]    flim_q, flim_d;

  // datapath helpers
  logic                charging, connected;
  pstate_e             nxt_ps;
  logic [MV_W-1:0]     iv, rc_inc, span;
  logic [PCT_W-1:0]    pct_inc;
  logic [RING_AW-1:0]  pos_sel;
  logic [FILL_W-1:0]   pos_inc;
  logic                ram_we, ram_re;
  logic [RING_W-1:0]   ram_rdata;
  logic [MV_W-1:0]     rd_mv;
  logic [PCT_W-1:0]    rd_pct;
  logic [LEN_CFG_W-1:0] len_raw;
  logic [FILL_W-1:0]   len_eff;
  logic                mul_done, div_done;
  logic [PROD_W-1:0]   prod;
  logic [DIV_W-1:0]    quo_mv, quo_pct;
  logic [DIV_W-1:0]    dvd_mv, dvd_pct;
  logic [DVS_W-1:0]    dvs_mv, dvs_pct;

  assign charging  = ~in_i.charge_level;
  assign connected = ~in_i.pg_pin_level;
  assign nxt_ps    = charging ? PS_CHRG : (connected ? PS_CONN : PS_DISC);

  // ramp helpers; zero interval acts as one
  assign iv      = (ri_q == '0) ? MV_W'(1) : ri_q;
  assign rc_inc  = (rc_q < iv) ? rc_q + MV_W'(1) : rc_q;
  assign pct_inc = held_pct_q + PCT_W'(1);
  assign span    = (full_q >= empty_q) ? full_q - empty_q : '0;

  // ring write slot wraps when the window shrank below the pointer
  assign pos_sel = (FILL_W'(pos_q) >= len_q) ? '0 : pos_q;
  assign pos_inc = FILL_W'(pos_sel) + FILL_W'(1);

  assign rd_mv  = ram_rdata[RING_W-1:PCT_W];
  assign rd_pct = ram_rdata[PCT_W-1:0];

  // filter length write: zero counts as one, clamp to ring depth
  assign len_raw = cfg_data_i[LEN_CFG_W-1:0];
  always_comb begin
    if (len_raw == '0) begin
      len_eff = FILL_W'(1);
    end else if (32'(len_raw) > 32'(MAX_WINDOW)) begin
      len_eff = FILL_W'(MAX_WINDOW);
    end else begin
      len_eff = FILL_W'(len_raw);
    end
  end

  // shared divider inputs: ramp uses the product over 100
  assign dvd_mv  = ramp_q ? DIV_W'(prod) : DIV_W'(smv_q);
  assign dvs_mv  = ramp_q ? PCT_SCALE : DVS_W'(fill_q);
  assign dvd_pct = DIV_W'(spct_q);
  assign dvs_pct = DVS_W'(fill_q);

  always_comb begin
    state_d     = state_q;
    run_d       = run_q;
    settle_d    = settle_q;
    rc_d        = rc_q;
    pos_d       = pos_q;
    fill_d      = fill_q;
    held_mv_d   = held_mv_q;
    held_pct_d  = held_pct_q;
    cnt_d       = cnt_q;
    rd_vld_d    = 1'b0;
    ramp_d      = ramp_q;
    mul_start_d = 1'b0;
    div_start_d = 1'b0;
    out_valid_d = out_valid_q;
    chg_d       = chg_q;
    con_d       = con_q;
    mv_d        = mv_q;
    pct_d       = pct_q;
    ok_d        = ok_q;
    smv_d       = smv_q;
    spct_d      = spct_q;
    out_d       = out_q;
    len_d       = len_q;
    ri_d        = ri_q;
    empty_d     = empty_q;
    full_d      = full_q;
    low_d       = low_q;
    flim_d      = flim_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          chg_d   = charging;
          con_d   = connected;
          mv_d    = in_i.raw_mv;
          pct_d   = in_i.raw_pct;
          ok_d    = in_i.adc_ok;
          run_d   = nxt_ps;
          // transition actions
          if (nxt_ps != run_q) begin
            if (nxt_ps == PS_CHRG) begin
              settle_d = '0;
              rc_d     = '0;
            end
            if (run_q == PS_CHRG && nxt_ps == PS_CONN) begin
              pos_d  = '0;
              fill_d = '0;
            end
            if (nxt_ps == PS_DISC) begin
              settle_d = SETTLE_COUNT;
              pos_d    = '0;
              fill_d   = '0;
            end
          end
          state_d = S_DECIDE;
        end
      end

      S_DECIDE: begin
        priority if (!ok_q) begin
          state_d = S_EMIT;
        end else if (run_q == PS_CHRG) begin
          if (rc_inc >= iv && held_pct_q < RAMP_CAP) begin
            rc_d        = '0;
            held_pct_d  = pct_inc;
            ramp_d      = 1'b1;
            mul_start_d = 1'b1;
            state_d     = S_MUL;
          end else begin
            rc_d    = rc_inc;
            state_d = S_EMIT;
          end
        end else if (settle_q != '0) begin
          settle_d = settle_q - 2'd1;
          state_d  = S_EMIT;
        end else begin
          // push sample, then sum entries 0..fill-1
          ram_we  = 1'b1;
          pos_d   = (pos_inc == len_q) ? '0 : RING_AW'(pos_inc);
          fill_d  = (fill_q < len_q) ? fill_q + FILL_W'(1) : fill_q;
          cnt_d   = '0;
          smv_d   = '0;
          spct_d  = '0;
          ramp_d  = 1'b0;
          state_d = S_SUM;
        end
      end

      S_SUM: begin
        ram_re   = (cnt_q < fill_q);
        rd_vld_d = ram_re;
        if (ram_re) begin
          cnt_d = cnt_q + FILL_W'(1);
        end
        if (rd_vld_q) begin
          smv_d  = smv_q + SUM_MV_W'(rd_mv);
          spct_d = spct_q + SUM_PCT_W'(rd_pct);
        end
        if (!ram_re && !rd_vld_q) begin
          div_start_d = 1'b1;
          state_d     = S_DIV;
        end
      end

      S_MUL: begin
        if (mul_done) begin
          div_start_d = 1'b1;
          state_d     = S_DIV;
        end
      end

      S_DIV: begin
        if (div_done) begin
          if (ramp_q) begin
            held_mv_d = empty_q + quo_mv[MV_W-1:0];
          end else begin
            held_mv_d  = quo_mv[MV_W-1:0];
            held_pct_d = quo_pct[PCT_W-1:0];
          end
          state_d = S_EMIT;
        end
      end

      S_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d.power_state    = run_q;
          out_d.is_charging    = chg_q;
          out_d.is_connected   = con_q;
          out_d.shown_mv       = held_mv_q;
          out_d.shown_pct      = held_pct_q;
          out_d.critically_low = (held_mv_q < low_q);
          out_d.fully_charged  = (held_pct_q >= flim_q) && con_q && !chg_q;
          out_d.meas_error     = !ok_q;
          out_valid_d          = 1'b1;
          state_d              = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // config writes must arrive only while idle; the block itself does not enforce this
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FILTER_LENGTH: begin
          if (len_eff != len_q) begin
            len_d      = len_eff;
            pos_d      = '0;
            fill_d     = '0;
            held_mv_d  = '0;
            held_pct_d = '0;
          end
        end
        CFG_RAMP_INTERVAL:  ri_d    = cfg_data_i[MV_W-1:0];
        CFG_EMPTY_MV:       empty_d = cfg_data_i[MV_W-1:0];
        CFG_FULL_MV:        full_d  = cfg_data_i[MV_W-1:0];
        CFG_LOW_LIMIT_MV:   low_d   = cfg_data_i[MV_W-1:0];
        CFG_FULL_LIMIT_PCT: flim_d  = cfg_data_i[PCT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      run_q       <= PS_DISC;
      settle_q    <= '0;
      rc_q        <= '0;
      pos_q       <= '0;
      fill_q      <= '0;
      held_mv_q   <= '0;
      held_pct_q  <= '0;
      cnt_q       <= '0;
      rd_vld_q    <= 1'b0;
      ramp_q      <= 1'b0;
      mul_start_q <= 1'b0;
      div_start_q <= 1'b0;
      out_valid_q <= 1'b0;
      chg_q       <= 1'b0;
      con_q       <= 1'b0;
      mv_q        <= '0;
      pct_q       <= '0;
      ok_q        <= 1'b0;
      smv_q       <= '0;
      spct_q      <= '0;
      out_q       <= '0;
      len_q       <= RST_FILTER_LENGTH;
      ri_q        <= RST_RAMP_INTERVAL;
      empty_q     <= RST_EMPTY_MV;
      full_q      <= RST_FULL_MV;
      low_q       <= RST_LOW_LIMIT_MV;
      flim_q      <= RST_FULL_LIMIT_PCT;
    end else begin
      state_q     <= state_d;
      run_q       <= run_d;
      settle_q    <= settle_d;
      rc_q        <= rc_d;
      pos_q       <= pos_d;
      fill_q      <= fill_d;
      held_mv_q   <= held_mv_d;
      held_pct_q  <= held_pct_d;
      cnt_q       <= cnt_d;
      rd_vld_q    <= rd_vld_d;
      ramp_q      <= ramp_d;
      mul_start_q <= mul_start_d;
      div_start_q <= div_start_d;
      out_valid_q <= out_valid_d;
      chg_q       <= chg_d;
      con_q       <= con_d;
      mv_q        <= mv_d;
      pct_q       <= pct_d;
      ok_q        <= ok_d;
      smv_q       <= smv_d;
      spct_q      <= spct_d;
      out_q       <= out_d;
      len_q       <= len_d;
      ri_q        <= ri_d;
      empty_q     <= empty_d;
      full_q      <= full_d;
      low_q       <= low_d;
      flim_q      <= flim_d;
    end
  end

  // moving-average ring: {mv, pct} per entry
  bgf_ram #(
    .WIDTH (RING_W),
    .DEPTH (MAX_WINDOW)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (pos_sel),
    .wdata_i ({mv_q, pct_q}),
    .re_i    (ram_re),
    .raddr_i (cnt_q[RING_AW-1:0]),
    .rdata_o (ram_rdata)
  );

  bgf_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start_q),
    .a_i     (held_pct_q),
    .b_i     (span),
    .done_o  (mul_done),
    .prod_o  (prod)
  );

  // millivolt divider, also serves the ramp's divide by 100
  bgf_div u_div_mv (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start_q),
    .dividend_i (dvd_mv),
    .divisor_i  (dvs_mv),
    .done_o     (div_done),
    .quo_o      (quo_mv)
  );

  // percent divider runs alongside for averages; its done matches the mv unit
  bgf_div u_div_pct (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start_q && !ramp_q),
    .dividend_i (dvd_pct),
    .divisor_i  (dvs_pct),
    .done_o     (),
    .quo_o      (quo_pct)
  );

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule
